/* rtl/core/tte_pkg.sv */
// Shared codes, widths and result types of the TFTP transfer engine.
`timescale 1ns / 1ps
package tte_pkg;

  localparam int BLOCK_BYTES = 512;
  localparam int LEN_W       = 10;
  localparam int BLK_W       = 16;
  localparam int RETRY_W     = 4;
  localparam int MAX_RES     = 3;
  localparam int QDEPTH      = 4;
  localparam int QPTR_W      = $clog2(QDEPTH);

  localparam logic [LEN_W-1:0]   BLOCK_LEN     = LEN_W'(BLOCK_BYTES);
  localparam logic [LEN_W-1:0]   HDR_LEN       = LEN_W'(4);
  localparam logic [RETRY_W-1:0] RETRIES_RESET = RETRY_W'(5);

  localparam logic [2:0] OP_START_READ  = 3'd0;
  localparam logic [2:0] OP_START_WRITE = 3'd1;
  localparam logic [2:0] OP_BLOCK_READY = 3'd2;
  localparam logic [2:0] OP_PACKET      = 3'd3;
  localparam logic [2:0] OP_TIMEOUT     = 3'd4;
  localparam logic [2:0] OP_SEND_FAILED = 3'd5;

  localparam logic [BLK_W-1:0] OPC_DATA  = 16'd3;
  localparam logic [BLK_W-1:0] OPC_ACK   = 16'd4;
  localparam logic [BLK_W-1:0] OPC_ERROR = 16'd5;

  localparam logic [2:0] ACT_FETCH_BLOCK   = 3'd0;
  localparam logic [2:0] ACT_SEND_DATA     = 3'd1;
  localparam logic [2:0] ACT_SEND_ACK      = 3'd2;
  localparam logic [2:0] ACT_WRITE_PAYLOAD = 3'd3;
  localparam logic [2:0] ACT_SEND_ERROR    = 3'd4;
  localparam logic [2:0] ACT_FINISHED      = 3'd5;

  localparam logic [1:0] ERR_SIZE    = 2'd0;
  localparam logic [1:0] ERR_MESSAGE = 2'd1;
  localparam logic [1:0] ERR_ACK_NUM = 2'd2;
  localparam logic [1:0] ERR_BLK_NUM = 2'd3;

  localparam logic [2:0] ST_COMPLETED   = 3'd0;
  localparam logic [2:0] ST_TIMED_OUT   = 3'd1;
  localparam logic [2:0] ST_PEER_ERROR  = 3'd2;
  localparam logic [2:0] ST_BAD_MESSAGE = 3'd3;
  localparam logic [2:0] ST_BAD_NUMBER  = 3'd4;
  localparam logic [2:0] ST_BAD_SIZE    = 3'd5;
  localparam logic [2:0] ST_SEND_FAILED = 3'd6;

  typedef struct packed {
    logic [2:0]       action;
    logic [BLK_W-1:0] block_id;
    logic [LEN_W-1:0] byte_count;
    logic [1:0]       error_kind;
    logic [2:0]       status;
  } res_t;

  typedef struct packed {
    res_t [MAX_RES-1:0] res;
    logic [1:0]         cnt;
  } entry_t;

  typedef struct packed {
    logic full;
    logic empty;
  } qstat_t;

  function automatic res_t mk_res(logic [2:0] action, logic [BLK_W-1:0] blk,
                                  logic [LEN_W-1:0] cnt, logic [1:0] err,
                                  logic [2:0] st);
    res_t r;
    r.action     = action;
    r.block_id   = blk;
    r.byte_count = cnt;
    r.error_kind = err;
    r.status     = st;
    return r;
  endfunction

endpackage

/* rtl/core/tte_front.sv */
// Front end: session state, event classification and result bundles.
`timescale 1ns / 1ps
module tte_front
  import tte_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  input  logic               cfg_wr_en,
  input  logic [RETRY_W-1:0] cfg_wr_data,
  input  logic               in_valid,
  input  logic               in_ready,
  input  logic [2:0]         in_operation,
  input  logic [LEN_W-1:0]   in_block_length,
  input  logic [BLK_W-1:0]   in_packet_opcode,
  input  logic [BLK_W-1:0]   in_packet_block,
  input  logic [LEN_W-1:0]   in_packet_length,
  output logic               push,
  output entry_t             push_entry
);

  typedef enum logic [1:0] {PH_IDLE, PH_FETCH, PH_ACK, PH_DATA} phase_t;

  phase_t             phase_r, phase_nxt;
  logic [BLK_W-1:0]   block_counter_r, block_counter_nxt;
  logic [RETRY_W-1:0] retries_left_r, retries_left_nxt;
  logic               final_block_r, final_block_nxt;
  logic [LEN_W-1:0]   current_length_r, current_length_nxt;
  logic [RETRY_W-1:0] max_retries_r;

  logic [RETRY_W-1:0] limit;
  logic [LEN_W-1:0]   blen_c;
  logic [LEN_W-1:0]   pay_raw;
  logic [LEN_W-1:0]   pay_c;
  logic [BLK_W-1:0]   blk_inc;
  logic [BLK_W-1:0]   blk_dec;
  logic [RETRY_W-1:0] rl_sat;
  logic [BLK_W-1:0]   want_opc;
  entry_t             ent;
  logic               accept;

  assign accept  = in_valid && in_ready;
  assign limit   = (max_retries_r == '0) ? RETRY_W'(1) : max_retries_r;
  assign blen_c  = (in_block_length > BLOCK_LEN) ? BLOCK_LEN : in_block_length;
  assign pay_raw = in_packet_length - HDR_LEN;
  assign pay_c   = (pay_raw > BLOCK_LEN) ? BLOCK_LEN : pay_raw;
  assign blk_inc = block_counter_r + BLK_W'(1);
  assign blk_dec = block_counter_r - BLK_W'(1);
  assign rl_sat  = (retries_left_r == '0) ? '0 : retries_left_r - RETRY_W'(1);
  assign want_opc = (phase_r == PH_ACK) ? OPC_ACK : OPC_DATA;

  always_comb begin
    phase_nxt          = phase_r;
    block_counter_nxt  = block_counter_r;
    retries_left_nxt   = retries_left_r;
    final_block_nxt    = final_block_r;
    current_length_nxt = current_length_r;
    ent                = '0;
    case (in_operation)
      OP_START_READ: begin
        phase_nxt          = PH_FETCH;
        block_counter_nxt  = '0;
        final_block_nxt    = 1'b0;
        current_length_nxt = '0;
        retries_left_nxt   = '0;
        ent.res[0] = mk_res(ACT_FETCH_BLOCK, '0, '0, '0, '0);
        ent.cnt    = 2'd1;
      end
      OP_START_WRITE: begin
        phase_nxt          = PH_DATA;
        block_counter_nxt  = '0;
        final_block_nxt    = 1'b0;
        current_length_nxt = '0;
        retries_left_nxt   = limit;
        ent.res[0] = mk_res(ACT_SEND_ACK, '0, '0, '0, '0);
        ent.cnt    = 2'd1;
      end
      OP_BLOCK_READY: begin
        if (phase_r == PH_FETCH) begin
          block_counter_nxt  = blk_inc;
          current_length_nxt = blen_c;
          final_block_nxt    = (blen_c < BLOCK_LEN);
          retries_left_nxt   = limit - RETRY_W'(1);
          phase_nxt          = PH_ACK;
          ent.res[0] = mk_res(ACT_SEND_DATA, blk_inc, blen_c, '0, '0);
          ent.cnt    = 2'd1;
        end
      end
      OP_PACKET: begin
        if (phase_r == PH_ACK || phase_r == PH_DATA) begin
          if (in_packet_length < HDR_LEN) begin
            phase_nxt  = PH_IDLE;
            ent.res[0] = mk_res(ACT_SEND_ERROR, '0, '0, ERR_SIZE, '0);
            ent.res[1] = mk_res(ACT_FINISHED, '0, '0, '0, ST_BAD_SIZE);
            ent.cnt    = 2'd2;
          end else if (in_packet_opcode == OPC_ERROR) begin
            phase_nxt  = PH_IDLE;
            ent.res[0] = mk_res(ACT_FINISHED, '0, '0, '0, ST_PEER_ERROR);
            ent.cnt    = 2'd1;
          end else if (in_packet_opcode != want_opc) begin
            phase_nxt  = PH_IDLE;
            ent.res[0] = mk_res(ACT_SEND_ERROR, '0, '0, ERR_MESSAGE, '0);
            ent.res[1] = mk_res(ACT_FINISHED, '0, '0, '0, ST_BAD_MESSAGE);
            ent.cnt    = 2'd2;
          end else if (phase_r == PH_ACK) begin
            if (in_packet_block != block_counter_r) begin
              if (in_packet_block == blk_dec) begin
                if (retries_left_r == '0) begin
                  phase_nxt  = PH_IDLE;
                  ent.res[0] = mk_res(ACT_FINISHED, '0, '0, '0, ST_TIMED_OUT);
                end else begin
                  retries_left_nxt = retries_left_r - RETRY_W'(1);
                  ent.res[0] = mk_res(ACT_SEND_DATA, block_counter_r,
                                      current_length_r, '0, '0);
                end
                ent.cnt = 2'd1;
              end else begin
                phase_nxt  = PH_IDLE;
                ent.res[0] = mk_res(ACT_SEND_ERROR, '0, '0, ERR_ACK_NUM, '0);
                ent.res[1] = mk_res(ACT_FINISHED, '0, '0, '0, ST_BAD_NUMBER);
                ent.cnt    = 2'd2;
              end
            end else if (final_block_r) begin
              phase_nxt  = PH_IDLE;
              ent.res[0] = mk_res(ACT_FINISHED, '0, '0, '0, ST_COMPLETED);
              ent.cnt    = 2'd1;
            end else begin
              phase_nxt  = PH_FETCH;
              ent.res[0] = mk_res(ACT_FETCH_BLOCK, '0, '0, '0, '0);
              ent.cnt    = 2'd1;
            end
          end else begin
            if (in_packet_block != blk_inc) begin
              phase_nxt  = PH_IDLE;
              ent.res[0] = mk_res(ACT_SEND_ERROR, '0, '0, ERR_BLK_NUM, '0);
              ent.res[1] = mk_res(ACT_FINISHED, '0, '0, '0, ST_BAD_NUMBER);
              ent.cnt    = 2'd2;
            end else begin
              block_counter_nxt  = blk_inc;
              current_length_nxt = pay_c;
              final_block_nxt    = (pay_raw < BLOCK_LEN);
              retries_left_nxt   = limit;
              ent.res[0] = mk_res(ACT_WRITE_PAYLOAD, '0, pay_c, '0, '0);
              ent.res[1] = mk_res(ACT_SEND_ACK, blk_inc, '0, '0, '0);
              ent.cnt    = 2'd2;
              if (pay_raw < BLOCK_LEN) begin
                phase_nxt  = PH_IDLE;
                ent.res[2] = mk_res(ACT_FINISHED, '0, '0, '0, ST_COMPLETED);
                ent.cnt    = 2'd3;
              end
            end
          end
        end
      end
      OP_TIMEOUT: begin
        if (phase_r == PH_ACK) begin
          if (retries_left_r == '0) begin
            phase_nxt  = PH_IDLE;
            ent.res[0] = mk_res(ACT_FINISHED, '0, '0, '0, ST_TIMED_OUT);
          end else begin
            retries_left_nxt = retries_left_r - RETRY_W'(1);
            ent.res[0] = mk_res(ACT_SEND_DATA, block_counter_r, current_length_r,
                                '0, '0);
          end
          ent.cnt = 2'd1;
        end else if (phase_r == PH_DATA) begin
          retries_left_nxt = rl_sat;
          ent.res[0] = mk_res(ACT_SEND_ACK, block_counter_r, '0, '0, '0);
          ent.cnt    = 2'd1;
          if (rl_sat == '0) begin
            phase_nxt  = PH_IDLE;
            ent.res[1] = mk_res(ACT_FINISHED, '0, '0, '0, ST_TIMED_OUT);
            ent.cnt    = 2'd2;
          end
        end
      end
      OP_SEND_FAILED: begin
        if (phase_r == PH_ACK || phase_r == PH_DATA) begin
          phase_nxt  = PH_IDLE;
          ent.res[0] = mk_res(ACT_FINISHED, '0, '0, '0, ST_SEND_FAILED);
          ent.cnt    = 2'd1;
        end
      end
      default: begin
      end
    endcase
  end

  assign push       = accept && (ent.cnt != 2'd0);
  assign push_entry = ent;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r          <= PH_IDLE;
      block_counter_r  <= '0;
      retries_left_r   <= '0;
      final_block_r    <= 1'b0;
      current_length_r <= '0;
      max_retries_r    <= RETRIES_RESET;
    end else begin
      if (cfg_wr_en) begin
        max_retries_r <= cfg_wr_data;
      end
      if (accept) begin
        phase_r          <= phase_nxt;
        block_counter_r  <= block_counter_nxt;
        retries_left_r   <= retries_left_nxt;
        final_block_r    <= final_block_nxt;
        current_length_r <= current_length_nxt;
      end
    end
  end

endmodule

/* rtl/core/tte_queue.sv */
// Short queue of result bundles between front and back end.
`timescale 1ns / 1ps
module tte_queue
  import tte_pkg::*;
(
  input  logic   clk,
  input  logic   rst_n,
  input  logic   push,
  input  entry_t push_entry,
  input  logic   pop,
  output entry_t head,
  output qstat_t stat
);

  entry_t            mem [QDEPTH];
  logic [QPTR_W-1:0] wr_ptr_r, rd_ptr_r;
  logic [QPTR_W:0]   count_r, count_nxt;

  always_comb begin
    count_nxt = count_r;
    if (push && !pop) begin
      count_nxt = count_r + (QPTR_W+1)'(1);
    end else if (pop && !push) begin
      count_nxt = count_r - (QPTR_W+1)'(1);
    end
  end

  assign stat.full  = (count_r == (QPTR_W+1)'(QDEPTH));
  assign stat.empty = (count_r == '0);
  assign head       = mem[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr_r] <= push_entry;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= wr_ptr_r + QPTR_W'(1);
      end
      if (pop) begin
        rd_ptr_r <= rd_ptr_r + QPTR_W'(1);
      end
      count_r <= count_nxt;
    end
  end

endmodule

/* rtl/core/tte_back.sv */
// Back end: unpack result bundles; one result per cycle while out_ready.
`timescale 1ns / 1ps
module tte_back
  import tte_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  input  entry_t           head,
  input  qstat_t           stat,
  output logic             pop,
  output logic             out_valid,
  input  logic             out_ready,
  output logic [2:0]       out_action,
  output logic [BLK_W-1:0] out_block_id,
  output logic [LEN_W-1:0] out_byte_count,
  output logic [1:0]       out_error_kind,
  output logic [2:0]       out_status,
  output logic             out_last
);

  entry_t     ent_r;
  logic [1:0] idx_r, idx_nxt;
  logic       busy_r, busy_nxt;
  logic       done;
  res_t       cur;

  assign cur      = ent_r.res[idx_r];
  assign out_last = (idx_r == ent_r.cnt - 2'd1);
  assign done     = busy_r && out_ready && out_last;
  assign pop      = !stat.empty && (!busy_r || done);

  always_comb begin
    idx_nxt  = idx_r;
    busy_nxt = busy_r;
    if (pop) begin
      idx_nxt  = 2'd0;
      busy_nxt = 1'b1;
    end else if (done) begin
      busy_nxt = 1'b0;
    end else if (busy_r && out_ready) begin
      idx_nxt = idx_r + 2'd1;
    end
  end

  assign out_valid      = busy_r;
  assign out_action     = cur.action;
  assign out_block_id   = cur.block_id;
  assign out_byte_count = cur.byte_count;
  assign out_error_kind = cur.error_kind;
  assign out_status     = cur.status;

  always_ff @(posedge clk) begin
    if (pop) begin
      ent_r <= head;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      idx_r  <= 2'd0;
    end else begin
      busy_r <= busy_nxt;
      idx_r  <= idx_nxt;
    end
  end

endmodule

/* rtl/core/tftp_transfer_engine.sv */
// An event's first result passes the bundle queue and the back end's entry
// register before it is offered. Events are taken one per cycle while the
// queue is not full; results leave one per cycle while out_ready is high.
// The four-entry bundle queue sets how far events run ahead of results.
// Reset (synchronous, active low) empties the queue, idles the session
// and sets max_retries to 5.
`timescale 1ns / 1ps
module tftp_transfer_engine
  import tte_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  input  logic               cfg_wr_en,
  input  logic [RETRY_W-1:0] cfg_wr_data,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [2:0]         in_operation,
  input  logic [LEN_W-1:0]   in_block_length,
  input  logic [BLK_W-1:0]   in_packet_opcode,
  input  logic [BLK_W-1:0]   in_packet_block,
  input  logic [LEN_W-1:0]   in_packet_length,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [2:0]         out_action,
  output logic [BLK_W-1:0]   out_block_id,
  output logic [LEN_W-1:0]   out_byte_count,
  output logic [1:0]         out_error_kind,
  output logic [2:0]         out_status,
  output logic               out_last
);

  logic   push;
  logic   pop;
  entry_t push_entry;
  entry_t head;
  qstat_t stat;

  assign in_ready = !stat.full;

  tte_front u_front (
    .clk              (clk),
    .rst_n            (rst_n),
    .cfg_wr_en        (cfg_wr_en),
    .cfg_wr_data      (cfg_wr_data),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_operation     (in_operation),
    .in_block_length  (in_block_length),
    .in_packet_opcode (in_packet_opcode),
    .in_packet_block  (in_packet_block),
    .in_packet_length (in_packet_length),
    .push             (push),
    .push_entry       (push_entry)
  );

  tte_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (push),
    .push_entry (push_entry),
    .pop        (pop),
    .head       (head),
    .stat       (stat)
  );

  tte_back u_back (
    .clk            (clk),
    .rst_n          (rst_n),
    .head           (head),
    .stat           (stat),
    .pop            (pop),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_action     (out_action),
    .out_block_id   (out_block_id),
    .out_byte_count (out_byte_count),
    .out_error_kind (out_error_kind),
    .out_status     (out_status),
    .out_last       (out_last)
  );

endmodule

/* rtl/core/tte_checker.sv */
// Port-level checks of the transfer engine, bound to the top level.
`timescale 1ns / 1ps
module tte_checker
  import tte_pkg::*;
(
  input logic             clk,
  input logic             rst_n,
  input logic             out_valid,
  input logic             out_ready,
  input logic [2:0]       out_action,
  input logic [BLK_W-1:0] out_block_id,
  input logic [LEN_W-1:0] out_byte_count,
  input logic             out_last
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_action)
      && $stable(out_block_id) && $stable(out_byte_count) && $stable(out_last))
    else $error("result changed while stalled");

  a_reset_idle: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result offered right after reset");

  a_finish_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_action == ACT_FINISHED |-> out_last)
    else $error("finished result not marked last");

  a_error_then_finish: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_action == ACT_SEND_ERROR |-> !out_last)
    else $error("error send not followed by finish");

endmodule

bind tftp_transfer_engine tte_checker u_tte_checker (
  .clk            (clk),
  .rst_n          (rst_n),
  .out_valid      (out_valid),
  .out_ready      (out_ready),
  .out_action     (out_action),
  .out_block_id   (out_block_id),
  .out_byte_count (out_byte_count),
  .out_last       (out_last)
);

/* dv/tftp_transfer_engine_tb.sv */
// Self-checking testbench for the queued TFTP transfer engine.
`timescale 1ns / 1ps
module tftp_transfer_engine_tb;
  import tte_pkg::*;

  localparam int CYCLE_LIMIT   = 200000;
  localparam int SETTLE_CYCLES = 8;
  localparam int RANDOM_PER_RUN = 100;
  localparam int DRAIN_EVERY   = 40;

  typedef enum logic [1:0] {SESS_IDLE, SESS_FETCH, SESS_ACK, SESS_DATA} sess_phase_t;

  typedef struct packed {
    logic [2:0]       op;
    logic [LEN_W-1:0] blen;
    logic [BLK_W-1:0] popc;
    logic [BLK_W-1:0] pblk;
    logic [LEN_W-1:0] plen;
  } tftp_evt_t;

  typedef struct packed {
    logic [2:0]       action;
    logic [BLK_W-1:0] block_id;
    logic [LEN_W-1:0] byte_count;
    logic [1:0]       error_kind;
    logic [2:0]       status;
    logic             last;
  } outcome_t;

  class transfer_scoreboard;
    sess_phase_t        phase;
    logic [BLK_W-1:0]   blk;
    logic [RETRY_W-1:0] retries_left;
    logic               final_blk;
    logic [LEN_W-1:0]   cur_len;
    logic [RETRY_W-1:0] max_retries;
    outcome_t           batch[$];
    outcome_t           pending[$];
    int                 errors;
    int                 results_seen;

    function new();
      phase        = SESS_IDLE;
      blk          = '0;
      retries_left = '0;
      final_blk    = 1'b0;
      cur_len      = '0;
      max_retries  = RETRIES_RESET;
      errors       = 0;
      results_seen = 0;
    endfunction

    function void set_retries(logic [RETRY_W-1:0] v);
      max_retries = v;
    endfunction

    function logic [RETRY_W-1:0] retry_limit();
      return (max_retries == '0) ? RETRY_W'(1) : max_retries;
    endfunction

    function void emit(logic [2:0] act, logic [BLK_W-1:0] b, logic [LEN_W-1:0] c,
                       logic [1:0] e, logic [2:0] s);
      outcome_t o;
      o.action     = act;
      o.block_id   = b;
      o.byte_count = c;
      o.error_kind = e;
      o.status     = s;
      o.last       = 1'b0;
      batch.push_back(o);
    endfunction

    function void close_session(logic [2:0] s);
      phase = SESS_IDLE;
      emit(ACT_FINISHED, '0, '0, '0, s);
    endfunction

    function void resend_block();
      if (retries_left == '0) begin
        close_session(ST_TIMED_OUT);
      end else begin
        retries_left = retries_left - 1'b1;
        emit(ACT_SEND_DATA, blk, cur_len, '0, ST_COMPLETED);
      end
    endfunction

    // Predict the actions caused by one accepted event; returns how many.
    function int note_event(tftp_evt_t ev);
      logic [LEN_W-1:0] len;
      logic [BLK_W-1:0] nxt;
      logic             fin;
      outcome_t         o;
      batch.delete();
      nxt = blk + 1'b1;
      case (ev.op)
        OP_START_READ: begin
          phase        = SESS_FETCH;
          blk          = '0;
          final_blk    = 1'b0;
          cur_len      = '0;
          retries_left = '0;
          emit(ACT_FETCH_BLOCK, '0, '0, '0, ST_COMPLETED);
        end
        OP_START_WRITE: begin
          phase        = SESS_DATA;
          blk          = '0;
          final_blk    = 1'b0;
          cur_len      = '0;
          retries_left = retry_limit();
          emit(ACT_SEND_ACK, '0, '0, '0, ST_COMPLETED);
        end
        OP_BLOCK_READY: begin
          if (phase == SESS_FETCH) begin
            len          = (ev.blen > BLOCK_LEN) ? BLOCK_LEN : ev.blen;
            blk          = nxt;
            cur_len      = len;
            final_blk    = (len < BLOCK_LEN);
            retries_left = retry_limit() - 1'b1;
            phase        = SESS_ACK;
            emit(ACT_SEND_DATA, blk, cur_len, '0, ST_COMPLETED);
          end
        end
        OP_PACKET: begin
          if (phase == SESS_ACK) begin
            if (ev.plen < HDR_LEN) begin
              emit(ACT_SEND_ERROR, '0, '0, ERR_SIZE, ST_COMPLETED);
              close_session(ST_BAD_SIZE);
            end else if (ev.popc == OPC_ERROR) begin
              close_session(ST_PEER_ERROR);
            end else if (ev.popc != OPC_ACK) begin
              emit(ACT_SEND_ERROR, '0, '0, ERR_MESSAGE, ST_COMPLETED);
              close_session(ST_BAD_MESSAGE);
            end else if (ev.pblk != blk) begin
              if (ev.pblk == BLK_W'(blk - 1'b1)) begin
                resend_block();
              end else begin
                emit(ACT_SEND_ERROR, '0, '0, ERR_ACK_NUM, ST_COMPLETED);
                close_session(ST_BAD_NUMBER);
              end
            end else if (final_blk) begin
              close_session(ST_COMPLETED);
            end else begin
              phase = SESS_FETCH;
              emit(ACT_FETCH_BLOCK, '0, '0, '0, ST_COMPLETED);
            end
          end else if (phase == SESS_DATA) begin
            if (ev.plen < HDR_LEN) begin
              emit(ACT_SEND_ERROR, '0, '0, ERR_SIZE, ST_COMPLETED);
              close_session(ST_BAD_SIZE);
            end else if (ev.popc == OPC_ERROR) begin
              close_session(ST_PEER_ERROR);
            end else if (ev.popc != OPC_DATA) begin
              emit(ACT_SEND_ERROR, '0, '0, ERR_MESSAGE, ST_COMPLETED);
              close_session(ST_BAD_MESSAGE);
            end else if (ev.pblk != nxt) begin
              emit(ACT_SEND_ERROR, '0, '0, ERR_BLK_NUM, ST_COMPLETED);
              close_session(ST_BAD_NUMBER);
            end else begin
              len = ev.plen - HDR_LEN;
              fin = (len < BLOCK_LEN);
              if (!fin) len = BLOCK_LEN;
              blk          = nxt;
              cur_len      = len;
              final_blk    = fin;
              retries_left = retry_limit();
              emit(ACT_WRITE_PAYLOAD, '0, cur_len, '0, ST_COMPLETED);
              emit(ACT_SEND_ACK, blk, '0, '0, ST_COMPLETED);
              if (fin) close_session(ST_COMPLETED);
            end
          end
        end
        OP_TIMEOUT: begin
          if (phase == SESS_ACK) begin
            resend_block();
          end else if (phase == SESS_DATA) begin
            emit(ACT_SEND_ACK, blk, '0, '0, ST_COMPLETED);
            if (retries_left != '0) retries_left = retries_left - 1'b1;
            if (retries_left == '0) close_session(ST_TIMED_OUT);
          end
        end
        OP_SEND_FAILED: begin
          if (phase == SESS_ACK || phase == SESS_DATA) close_session(ST_SEND_FAILED);
        end
        default: ;
      endcase
      if (batch.size() > 0) begin
        o = batch.pop_back();
        o.last = 1'b1;
        batch.push_back(o);
      end
      foreach (batch[i]) pending.push_back(batch[i]);
      return batch.size();
    endfunction

    function void compare_field(string what, logic [BLK_W-1:0] exp_v, logic [BLK_W-1:0] got_v);
      if (exp_v !== got_v) begin
        $display("%0t: %s mismatch: expected %0d, actual %0d", $time, what, exp_v, got_v);
        errors++;
      end
    endfunction

    function void check_result(outcome_t got);
      outcome_t want;
      results_seen++;
      if (pending.size() == 0) begin
        $display("%0t: unexpected result: expected none, actual action %0d block %0d count %0d",
                 $time, got.action, got.block_id, got.byte_count);
        errors++;
      end else begin
        want = pending.pop_front();
        compare_field("action", BLK_W'(want.action), BLK_W'(got.action));
        compare_field("block_id", want.block_id, got.block_id);
        compare_field("byte_count", BLK_W'(want.byte_count), BLK_W'(got.byte_count));
        compare_field("error_kind", BLK_W'(want.error_kind), BLK_W'(got.error_kind));
        compare_field("status", BLK_W'(want.status), BLK_W'(got.status));
        compare_field("last", BLK_W'(want.last), BLK_W'(got.last));
      end
    endfunction
  endclass

  logic               clk = 1'b0;
  logic               rst_n = 1'b0;
  logic               cfg_wr_en = 1'b0;
  logic [RETRY_W-1:0] cfg_wr_data = '0;
  logic               in_valid = 1'b0;
  logic               in_ready;
  logic [2:0]         in_operation = '0;
  logic [LEN_W-1:0]   in_block_length = '0;
  logic [BLK_W-1:0]   in_packet_opcode = '0;
  logic [BLK_W-1:0]   in_packet_block = '0;
  logic [LEN_W-1:0]   in_packet_length = '0;
  logic               out_valid;
  logic               out_ready = 1'b0;
  logic [2:0]         out_action;
  logic [BLK_W-1:0]   out_block_id;
  logic [LEN_W-1:0]   out_byte_count;
  logic [1:0]         out_error_kind;
  logic [2:0]         out_status;
  logic               out_last;

  transfer_scoreboard sb;
  tftp_evt_t          seen_evt;
  outcome_t           seen_res;
  int                 produced;
  int                 accepted_count = 0;
  int                 productive_count = 0;
  int                 cycle_count = 0;
  int                 send_idle_pct = 0;
  int                 recv_idle_pct = 0;

  tftp_transfer_engine dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .cfg_wr_en        (cfg_wr_en),
    .cfg_wr_data      (cfg_wr_data),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_operation     (in_operation),
    .in_block_length  (in_block_length),
    .in_packet_opcode (in_packet_opcode),
    .in_packet_block  (in_packet_block),
    .in_packet_length (in_packet_length),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_action       (out_action),
    .out_block_id     (out_block_id),
    .out_byte_count   (out_byte_count),
    .out_error_kind   (out_error_kind),
    .out_status       (out_status),
    .out_last         (out_last)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("%0t: timeout after %0d cycles, %0d results outstanding",
               $time, cycle_count, sb.pending.size());
      $display("*** FAILED ***");
      $finish;
    end
  end

  always @(negedge clk) begin
    out_ready <= ($urandom_range(99, 0) >= recv_idle_pct);
  end

  // check results before noting new transactions: a result never belongs to this edge's input
  always @(posedge clk) begin
    if (rst_n) begin
      if (out_valid && out_ready) begin
        seen_res.action     = out_action;
        seen_res.block_id   = out_block_id;
        seen_res.byte_count = out_byte_count;
        seen_res.error_kind = out_error_kind;
        seen_res.status     = out_status;
        seen_res.last       = out_last;
        sb.check_result(seen_res);
      end
      if (in_valid && in_ready) begin
        seen_evt.op   = in_operation;
        seen_evt.blen = in_block_length;
        seen_evt.popc = in_packet_opcode;
        seen_evt.pblk = in_packet_block;
        seen_evt.plen = in_packet_length;
        produced = sb.note_event(seen_evt);
        accepted_count++;
        if (produced > 0) productive_count++;
      end
    end
  end

  function automatic tftp_evt_t evt(logic [2:0] op, logic [LEN_W-1:0] blen,
                                    logic [BLK_W-1:0] popc, logic [BLK_W-1:0] pblk,
                                    logic [LEN_W-1:0] plen);
    tftp_evt_t ev;
    ev.op   = op;
    ev.blen = blen;
    ev.popc = popc;
    ev.pblk = pblk;
    ev.plen = plen;
    return ev;
  endfunction

  task automatic send_event(input tftp_evt_t ev);
    int target;
    while ($urandom_range(99, 0) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid         <= 1'b1;
    in_operation     <= ev.op;
    in_block_length  <= ev.blen;
    in_packet_opcode <= ev.popc;
    in_packet_block  <= ev.pblk;
    in_packet_length <= ev.plen;
    target = accepted_count + 1;
    do @(negedge clk); while (accepted_count < target);
  endtask

  // hold the sender until every expected result is back, then let the pipe settle
  task automatic drain_results();
    in_valid <= 1'b0;
    while (sb.pending.size() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic write_retries(input logic [RETRY_W-1:0] v);
    drain_results();
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= v;
    sb.set_retries(v);
    @(negedge clk);
    cfg_wr_en <= 1'b0;
  endtask

  // mostly well-formed traffic for the current session phase, some noise
  function automatic tftp_evt_t pick_event();
    tftp_evt_t ev;
    int r;
    int s;
    r = $urandom_range(99, 0);
    s = $urandom_range(99, 0);
    ev = evt(OP_TIMEOUT, LEN_W'($urandom_range(512, 0)), BLK_W'($urandom_range(16'hFFFF, 0)),
             BLK_W'($urandom_range(16'hFFFF, 0)), LEN_W'($urandom_range(516, 0)));
    if (r < 12) begin
      ev.op = 3'($urandom_range(7, 0));
      case ($urandom_range(3, 0))
        0: ev.popc = OPC_DATA;
        1: ev.popc = OPC_ACK;
        2: ev.popc = OPC_ERROR;
        default: ;
      endcase
      case ($urandom_range(3, 0))
        0: ev.pblk = sb.blk;
        1: ev.pblk = sb.blk + 1'b1;
        2: ev.pblk = sb.blk - 1'b1;
        default: ;
      endcase
      if (s < 15) ev.plen = LEN_W'($urandom_range(3, 0));
      else if (s < 20) ev.plen = LEN_W'($urandom_range(1023, 517));
      if (s >= 95) ev.blen = LEN_W'($urandom_range(1023, 513));
    end else begin
      case (sb.phase)
        SESS_FETCH: begin
          ev.op = OP_BLOCK_READY;
          if (s < 70) ev.blen = BLOCK_LEN;
          else if (s < 97) ev.blen = LEN_W'($urandom_range(511, 0));
          else ev.blen = LEN_W'($urandom_range(1023, 513));
        end
        SESS_ACK: begin
          if (s < 80) begin
            ev.op   = OP_PACKET;
            ev.popc = OPC_ACK;
            ev.pblk = (s < 70) ? sb.blk : BLK_W'(sb.blk - 1'b1);
            ev.plen = LEN_W'($urandom_range(516, 4));
          end else if (s < 95) begin
            ev.op = OP_TIMEOUT;
          end else begin
            ev.op = OP_SEND_FAILED;
          end
        end
        SESS_DATA: begin
          if (s < 72) begin
            ev.op   = OP_PACKET;
            ev.popc = OPC_DATA;
            ev.pblk = sb.blk + 1'b1;
            if (r < 70) ev.plen = LEN_W'(516);
            else if (r < 97) ev.plen = LEN_W'($urandom_range(515, 4));
            else ev.plen = LEN_W'($urandom_range(1023, 517));
          end else if (s < 94) begin
            ev.op = OP_TIMEOUT;
          end else if (s < 97) begin
            ev.op   = OP_PACKET;
            ev.popc = OPC_ERROR;
          end else begin
            ev.op = OP_SEND_FAILED;
          end
        end
        default: ev.op = ($urandom_range(1, 0) == 1) ? OP_START_WRITE : OP_START_READ;
      endcase
    end
    return ev;
  endfunction

  logic [RETRY_W-1:0] run_retries[3] = '{RETRY_W'(1), RETRY_W'(15), RETRY_W'(3)};
  int                 run_send_idle[3] = '{9, 84, 0};
  int                 run_recv_idle[3] = '{84, 9, 0};

  initial begin
    int goal;
    int mark;
    sb = new();
    repeat (12) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    send_event(evt(3'd6, 10'h3FF, 16'hFFFF, 16'hFFFF, 10'h3FF));
    send_event(evt(3'd7, 10'h155, 16'hAAAA, 16'h5555, 10'h2AA));
    send_event(evt(OP_BLOCK_READY, 10'd512, '0, '0, '0));
    send_event(evt(OP_START_READ, '0, '0, '0, '0));
    send_event(evt(OP_BLOCK_READY, 10'd1023, '0, '0, '0));
    send_event(evt(OP_PACKET, '0, OPC_ACK, 16'd1, 10'd4));
    send_event(evt(OP_BLOCK_READY, 10'd512, '0, '0, '0));
    send_event(evt(OP_PACKET, '0, OPC_ACK, 16'd1, 10'd4));
    send_event(evt(OP_TIMEOUT, '0, '0, '0, '0));
    send_event(evt(OP_PACKET, '0, OPC_ACK, 16'hFFFF, 10'd516));
    send_event(evt(OP_START_WRITE, '0, '0, '0, '0));
    send_event(evt(OP_PACKET, '0, OPC_DATA, 16'd1, 10'd1023));
    send_event(evt(OP_START_READ, '0, '0, '0, '0));
    send_event(evt(OP_BLOCK_READY, 10'd0, '0, '0, '0));
    send_event(evt(OP_PACKET, '0, OPC_ACK, 16'd1, 10'd3));
    send_event(evt(OP_START_WRITE, '0, '0, '0, '0));
    send_event(evt(OP_PACKET, '0, OPC_DATA, 16'd1, 10'd4));
    send_event(evt(OP_START_WRITE, '0, '0, '0, '0));
    send_event(evt(OP_PACKET, '0, OPC_ERROR, 16'd0, 10'd4));
    send_event(evt(OP_START_WRITE, '0, '0, '0, '0));
    send_event(evt(OP_PACKET, '0, OPC_DATA, 16'd5, 10'd100));
    send_event(evt(OP_START_WRITE, '0, '0, '0, '0));
    send_event(evt(OP_SEND_FAILED, '0, '0, '0, '0));
    write_retries(RETRY_W'(0));
    send_event(evt(OP_START_READ, '0, '0, '0, '0));
    send_event(evt(OP_BLOCK_READY, 10'd512, '0, '0, '0));
    send_event(evt(OP_TIMEOUT, '0, '0, '0, '0));

    for (int run = 0; run < 3; run++) begin
      write_retries(run_retries[run]);
      send_idle_pct = run_send_idle[run];
      recv_idle_pct = run_recv_idle[run];
      goal = productive_count + RANDOM_PER_RUN;
      mark = productive_count;
      while (productive_count < goal) begin
        send_event(pick_event());
        if (productive_count - mark >= DRAIN_EVERY) begin
          drain_results();
          mark = productive_count;
        end
      end
    end

    drain_results();
    $display("Covered %0d transactions (%0d with results), %0d results checked,",
             accepted_count, productive_count, sb.results_seen);
    $display("read and write sessions under retry limits 5, 0, 1, 15 and 3 with both ports stalling.");
    if (sb.errors == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("%0d mismatches", sb.errors);
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
